// File: rtl/dual_timer_counter_defines.svh
// Assertion macros for the dual timer/counter.
`ifndef DUAL_TIMER_COUNTER_DEFINES_SVH
`define DUAL_TIMER_COUNTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DTC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dtc assertion failed");
`define DTC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("dtc reset assertion failed");
`else
`define DTC_ASSERT(lbl, prop)
`define DTC_ASSERT_RST(lbl, prop)
`endif

`endif

// File: rtl/dtc_pkg.sv
package dtc_pkg;

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_WR   = 2'd1;
    localparam logic [1:0] REQ_RD   = 2'd2;

    localparam logic [2:0] SEL_CTRL = 3'd0;
    localparam logic [2:0] SEL_LO0  = 3'd1;
    localparam logic [2:0] SEL_HI0  = 3'd2;
    localparam logic [2:0] SEL_LO1  = 3'd3;
    localparam logic [2:0] SEL_HI1  = 3'd4;

    localparam logic [1:0] MODE_13BIT  = 2'd0;
    localparam logic [1:0] MODE_16BIT  = 2'd1;
    localparam logic [1:0] MODE_RELOAD = 2'd2;
    localparam logic [1:0] MODE_SPLIT  = 2'd3;

    localparam logic [7:0] LO13_MASK = 8'h1f;

    // control byte bit positions
    localparam int RUN0_POS  = 4;
    localparam int FLAG0_POS = 5;
    localparam int RUN1_POS  = 6;
    localparam int FLAG1_POS = 7;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] reg_sel;
        logic [7:0] wr_data;
        logic       gate0_pin;
        logic       gate1_pin;
        logic       t0_edge;
        logic       t1_edge;
    } t_in_word;

    typedef struct packed {
        logic [7:0] rd_data;
        logic       flag0;
        logic       flag1;
    } t_out_word;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
        logic       ovf;
    } t_step;

    // one count step in 13-bit, 16-bit or auto-reload mode
    function automatic t_step step_timer(logic [1:0] mode, logic [7:0] lo, logic [7:0] hi);
        t_step      r;
        logic [7:0] nl;
        r.lo  = lo;
        r.hi  = hi;
        r.ovf = 1'b0;
        nl    = lo + 8'd1;
        case (mode)
            MODE_RELOAD: begin
                if (nl == 8'd0) begin
                    r.lo  = hi;
                    r.ovf = 1'b1;
                end else begin
                    r.lo = nl;
                end
            end
            MODE_13BIT, MODE_16BIT: begin
                if (mode == MODE_13BIT) begin
                    nl = nl & LO13_MASK;
                end
                r.lo = nl;
                if (nl == 8'd0) begin
                    r.hi  = hi + 8'd1;
                    r.ovf = (hi == 8'hff);
                end
            end
            default: begin
                r.lo = lo;
            end
        endcase
        return r;
    endfunction

endpackage

// File: rtl/dual_timer_counter.sv
// Dual timer/counter, one word per request.
// Each accepted word is registered in r_in; o_valid rises once its reply is in r_out.
// Throughput: one word per cycle while i_ready keeps the output free; input register
// feeds the timer update, result register holds the reply.
// Reset: synchronous active low; counts, control byte and mode byte clear to 0.
`include "dual_timer_counter_defines.svh"

module dual_timer_counter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  dtc_pkg::t_in_word  i_in,
    output logic               o_valid,
    input  logic               i_ready,
    output dtc_pkg::t_out_word o_out
);
    import dtc_pkg::*;

    logic [7:0] r_mode_byte;
    logic      r_in_vld;
    t_in_word  r_in;
    logic      r_out_vld;
    t_out_word r_out;
    t_out_word res;
    logic      out_free;
    logic      adv;

    assign out_free = !r_out_vld || i_ready;
    assign adv      = r_in_vld && out_free;
    assign o_ready  = !r_in_vld || out_free;
    assign o_valid  = r_out_vld;
    assign o_out    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_byte <= 8'd0;
        end else if (i_cfg_we) begin
            r_mode_byte <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_in;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    dtc_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_item  (r_in),
        .i_mode  (r_mode_byte),
        .o_res   (res)
    );

    `DTC_ASSERT(a_adv_fills_out, adv |=> r_out_vld)
    `DTC_ASSERT(a_stalled_in_holds, (r_in_vld && !out_free) |=> (r_in_vld && $stable(r_in)))
    `DTC_ASSERT_RST(a_reset_empty, !i_rst_n |=> (!r_out_vld && !r_in_vld))

endmodule

// File: rtl/dtc_exec.sv
`include "dual_timer_counter_defines.svh"

module dtc_exec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  dtc_pkg::t_in_word i_item,
    input  logic [7:0]        i_mode,
    output dtc_pkg::t_out_word o_res
);
    import dtc_pkg::*;

    logic [7:0] r_ctl, r_lo0, r_hi0, r_lo1, r_hi1;
    logic [7:0] n_ctl, n_lo0, n_hi0, n_lo1, n_hi1;
    logic [1:0] mode0, mode1;
    logic       step0, step1;
    t_step      s0, s1;
    logic [7:0] rd;

    assign mode0 = i_mode[1:0];
    assign mode1 = i_mode[5:4];

    assign step0 = r_ctl[RUN0_POS] && (!i_mode[3] || i_item.gate0_pin)
                   && (!i_mode[2] || i_item.t0_edge);
    assign step1 = r_ctl[RUN1_POS] && (mode1 != MODE_SPLIT)
                   && (!i_mode[7] || i_item.gate1_pin)
                   && (!i_mode[6] || i_item.t1_edge);

    assign s0 = step_timer(mode0, r_lo0, r_hi0);
    assign s1 = step_timer(mode1, r_lo1, r_hi1);

    always_comb begin
        n_ctl = r_ctl;
        n_lo0 = r_lo0;
        n_hi0 = r_hi0;
        n_lo1 = r_lo1;
        n_hi1 = r_hi1;
        rd    = 8'd0;
        case (i_item.req_type)
            REQ_TICK: begin
                if (step0) begin
                    if (mode0 == MODE_SPLIT) begin
                        n_lo0 = r_lo0 + 8'd1;
                        n_hi0 = r_hi0 + 8'd1;
                    end else begin
                        n_lo0 = s0.lo;
                        n_hi0 = s0.hi;
                        if (s0.ovf) begin
                            n_ctl[FLAG0_POS] = 1'b1;
                        end
                    end
                end
                if (step1) begin
                    n_lo1 = s1.lo;
                    n_hi1 = s1.hi;
                    if (s1.ovf) begin
                        n_ctl[FLAG1_POS] = 1'b1;
                    end
                end
            end
            REQ_WR: begin
                case (i_item.reg_sel)
                    SEL_CTRL: n_ctl = i_item.wr_data;
                    SEL_LO0:  n_lo0 = i_item.wr_data;
                    SEL_HI0:  n_hi0 = i_item.wr_data;
                    SEL_LO1:  n_lo1 = i_item.wr_data;
                    SEL_HI1:  n_hi1 = i_item.wr_data;
                    default:  n_ctl = r_ctl;
                endcase
            end
            REQ_RD: begin
                case (i_item.reg_sel)
                    SEL_CTRL: rd = r_ctl;
                    SEL_LO0:  rd = r_lo0;
                    SEL_HI0:  rd = r_hi0;
                    SEL_LO1:  rd = r_lo1;
                    SEL_HI1:  rd = r_hi1;
                    default:  rd = 8'd0;
                endcase
            end
            default: begin
                rd = 8'd0;
            end
        endcase
    end

    assign o_res.rd_data = rd;
    assign o_res.flag0   = n_ctl[FLAG0_POS];
    assign o_res.flag1   = n_ctl[FLAG1_POS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= 8'd0;
            r_lo0 <= 8'd0;
            r_hi0 <= 8'd0;
            r_lo1 <= 8'd0;
            r_hi1 <= 8'd0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
            r_lo0 <= n_lo0;
            r_hi0 <= n_hi0;
            r_lo1 <= n_lo1;
            r_hi1 <= n_hi1;
        end
    end

    // flag is sticky until software rewrites the control byte
    `DTC_ASSERT(a_flag0_sticky, (r_ctl[FLAG0_POS] && !(i_en && i_item.req_type == REQ_WR && i_item.reg_sel == SEL_CTRL)) |=> r_ctl[FLAG0_POS])
    `DTC_ASSERT(a_reload_hi_hold, (i_en && i_item.req_type == REQ_TICK && mode1 == MODE_RELOAD) |=> $stable(r_hi1))
    `DTC_ASSERT(a_t1_split_halt, (i_en && i_item.req_type == REQ_TICK && mode1 == MODE_SPLIT) |=> ($stable(r_lo1) && $stable(r_hi1)))

endmodule

// File: tb/tb.sv
import dtc_pkg::*;

localparam int T0_CT_BIT   = 2;
localparam int T0_GATE_BIT = 3;
localparam int T1_CT_BIT   = 6;
localparam int T1_GATE_BIT = 7;

class timer_tracker;
    logic [7:0] mode_byte;
    logic [7:0] ctrl;
    logic [7:0] lo0, hi0, lo1, hi1;
    t_out_word  pending_replies[$];
    int         errors;
    int         checked;
    int         overflows;

    function void set_mode(logic [7:0] v);
        mode_byte = v;
    endfunction

    function int pending();
        return pending_replies.size();
    endfunction

    task report(string what);
        $display("mismatch at reply %0d: %s", checked, what);
        errors++;
    endtask

    // one count step in modes 0..2, returns 1 on overflow
    function bit advance_count(logic [1:0] mode, inout logic [7:0] lo, inout logic [7:0] hi);
        if (mode == MODE_RELOAD) begin
            lo = lo + 8'd1;
            if (lo == 8'd0) begin
                lo = hi;
                return 1'b1;
            end
            return 1'b0;
        end
        lo = lo + 8'd1;
        if (mode == MODE_13BIT) begin
            lo = lo & LO13_MASK;
        end
        if (lo == 8'd0) begin
            hi = hi + 8'd1;
            return (hi == 8'd0);
        end
        return 1'b0;
    endfunction

    function void machine_tick(t_in_word w);
        logic [1:0] m0, m1;
        bit         run0, run1, ev0, ev1;
        m0   = mode_byte[1:0];
        m1   = mode_byte[5:4];
        run0 = ctrl[RUN0_POS] && (!mode_byte[T0_GATE_BIT] || w.gate0_pin);
        ev0  = !mode_byte[T0_CT_BIT] || w.t0_edge;
        run1 = ctrl[RUN1_POS] && (m1 != MODE_SPLIT) && (!mode_byte[T1_GATE_BIT] || w.gate1_pin);
        ev1  = !mode_byte[T1_CT_BIT] || w.t1_edge;
        if (run0 && ev0) begin
            if (m0 == MODE_SPLIT) begin
                lo0 = lo0 + 8'd1;
                hi0 = hi0 + 8'd1;
            end else if (advance_count(m0, lo0, hi0)) begin
                ctrl[FLAG0_POS] = 1'b1;
                overflows++;
            end
        end
        if (run1 && ev1) begin
            if (advance_count(m1, lo1, hi1)) begin
                ctrl[FLAG1_POS] = 1'b1;
                overflows++;
            end
        end
    endfunction

    function void note_word(t_in_word w);
        t_out_word r;
        r.rd_data = 8'd0;
        case (w.req_type)
            REQ_TICK: begin
                machine_tick(w);
            end
            REQ_WR: begin
                case (w.reg_sel)
                    SEL_CTRL: ctrl = w.wr_data;
                    SEL_LO0:  lo0  = w.wr_data;
                    SEL_HI0:  hi0  = w.wr_data;
                    SEL_LO1:  lo1  = w.wr_data;
                    SEL_HI1:  hi1  = w.wr_data;
                    default: ;
                endcase
            end
            REQ_RD: begin
                case (w.reg_sel)
                    SEL_CTRL: r.rd_data = ctrl;
                    SEL_LO0:  r.rd_data = lo0;
                    SEL_HI0:  r.rd_data = hi0;
                    SEL_LO1:  r.rd_data = lo1;
                    SEL_HI1:  r.rd_data = hi1;
                    default:  r.rd_data = 8'd0;
                endcase
            end
            default: ;
        endcase
        r.flag0 = ctrl[FLAG0_POS];
        r.flag1 = ctrl[FLAG1_POS];
        pending_replies.push_back(r);
    endfunction

    task check_reply(t_out_word got);
        t_out_word want;
        if (pending_replies.size() == 0) begin
            report($sformatf("reply %h with nothing outstanding", got));
            return;
        end
        want = pending_replies.pop_front();
        if (got.rd_data !== want.rd_data)
            report($sformatf("rd_data %h, want %h", got.rd_data, want.rd_data));
        if (got.flag0 !== want.flag0)
            report($sformatf("flag0 %b, want %b", got.flag0, want.flag0));
        if (got.flag1 !== want.flag1)
            report($sformatf("flag1 %b, want %b", got.flag1, want.flag1));
        checked++;
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [7:0] i_cfg_data;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_in;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_out;

    timer_tracker tracker = new;

    int snd_idle_pct;
    int rcv_idle_pct;
    int stall_requests;
    int stall_served;
    int hold_left;
    int words_sent;
    int modes_used;

    dual_timer_counter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) tracker.set_mode(i_cfg_data);
            if (i_valid && o_ready) tracker.note_word(i_in);
            if (o_valid && i_ready) tracker.check_reply(o_out);
        end
    end

    // receiver; a stall request holds ready low for a long stretch
    always @(negedge i_clk) begin
        if (stall_requests != stall_served) begin
            stall_served++;
            hold_left = 60;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready = 1'b0;
        end else begin
            i_ready = ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    function automatic t_in_word make_word(logic [1:0] req, logic [2:0] sel,
                                           logic [7:0] data, logic [3:0] pins);
        t_in_word w;
        w.req_type  = req;
        w.reg_sel   = sel;
        w.wr_data   = data;
        w.gate0_pin = pins[3];
        w.gate1_pin = pins[2];
        w.t0_edge   = pins[1];
        w.t1_edge   = pins[0];
        return w;
    endfunction

    function automatic t_in_word random_tick();
        logic [3:0] pins;
        pins = {($urandom_range(3) != 0), ($urandom_range(3) != 0), 2'($urandom)};
        return make_word(REQ_TICK, 3'($urandom), 8'($urandom), pins);
    endfunction

    function automatic logic [7:0] near_top();
        case ($urandom_range(3))
            0: return 8'hff - 8'($urandom_range(3));
            1: return 8'h1f - 8'($urandom_range(3));
            2: return 8'($urandom);
            default: return 8'hfe;
        endcase
    endfunction

    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < snd_idle_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_in    = w;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_valid = 1'b0;
        while (tracker.pending() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [7:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        modes_used++;
    endtask

    // control write with run bits mostly on, counts near wrap, ticks, read back
    task automatic run_sequence();
        logic [7:0] c;
        c = 8'($urandom);
        c[RUN0_POS] = ($urandom_range(4) != 0);
        c[RUN1_POS] = ($urandom_range(4) != 0);
        send_word(make_word(REQ_WR, SEL_CTRL, c, 4'($urandom)));
        if ($urandom_range(1)) send_word(make_word(REQ_WR, SEL_LO0, near_top(), 4'($urandom)));
        if ($urandom_range(1)) send_word(make_word(REQ_WR, SEL_HI0, near_top(), 4'($urandom)));
        if ($urandom_range(1)) send_word(make_word(REQ_WR, SEL_LO1, near_top(), 4'($urandom)));
        if ($urandom_range(1)) send_word(make_word(REQ_WR, SEL_HI1, near_top(), 4'($urandom)));
        repeat ($urandom_range(3, 20)) send_word(random_tick());
        repeat ($urandom_range(1, 3))
            send_word(make_word(REQ_RD, 3'($urandom_range(4)), 8'($urandom), 4'($urandom)));
    endtask

    initial begin
        logic [7:0] phase_modes[10];
        int         start;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = 8'd0;
        i_valid        = 1'b0;
        i_in           = '0;
        i_ready        = 1'b0;
        snd_idle_pct   = 17;
        rcv_idle_pct   = 84;
        stall_requests = 0;
        stall_served   = 0;
        hold_left      = 0;
        words_sent     = 0;
        modes_used     = 0;
        tracker.set_mode(8'd0);
        tracker.ctrl = 8'd0;
        tracker.lo0  = 8'd0;
        tracker.hi0  = 8'd0;
        tracker.lo1  = 8'd0;
        tracker.hi1  = 8'd0;

        phase_modes = '{8'h11, 8'hff, 8'h22, 8'h00, 8'hcc,
                        8'h33, 8'($urandom), 8'ha1, 8'h12, 8'($urandom)};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // 13-bit mode: low byte wrap with upper bits set carries into high byte
        write_mode(8'h00);
        send_word(make_word(REQ_RD, SEL_CTRL, 8'h00, 4'hf));
        send_word(make_word(REQ_RD, SEL_LO0, 8'hff, 4'h0));
        send_word(make_word(REQ_RD, SEL_HI1, 8'h00, 4'h0));
        send_word(make_word(REQ_WR, SEL_LO0, 8'hff, 4'hf));
        send_word(make_word(REQ_WR, SEL_HI0, 8'hff, 4'h0));
        send_word(make_word(REQ_WR, SEL_CTRL, 8'h50, 4'hf));
        send_word(make_word(REQ_TICK, 3'd7, 8'hff, 4'h0));
        send_word(make_word(REQ_RD, SEL_CTRL, 8'h00, 4'h0));
        send_word(make_word(REQ_WR, 3'd5, 8'haa, 4'h0));
        send_word(make_word(REQ_RD, 3'd7, 8'h55, 4'h0));
        send_word(make_word(2'd3, SEL_HI0, 8'hff, 4'hf));
        send_word(make_word(REQ_WR, SEL_CTRL, 8'h00, 4'h0));

        // timer 0 auto-reload, timer 1 halted
        write_mode(8'h32);
        send_word(make_word(REQ_WR, SEL_HI0, 8'h80, 4'h0));
        send_word(make_word(REQ_WR, SEL_LO0, 8'hff, 4'h0));
        send_word(make_word(REQ_WR, SEL_CTRL, 8'h50, 4'h0));
        send_word(make_word(REQ_TICK, SEL_CTRL, 8'h00, 4'hf));
        send_word(make_word(REQ_RD, SEL_LO0, 8'h00, 4'h0));
        send_word(make_word(REQ_RD, SEL_LO1, 8'h00, 4'h0));

        // timer 0 split, gated counter; timer 1 auto-reload
        write_mode(8'h2f);
        send_word(make_word(REQ_WR, SEL_LO0, 8'hff, 4'h0));
        send_word(make_word(REQ_WR, SEL_HI0, 8'hff, 4'h0));
        send_word(make_word(REQ_WR, SEL_CTRL, 8'h50, 4'h0));
        send_word(make_word(REQ_TICK, SEL_CTRL, 8'h00, 4'b1000));
        send_word(make_word(REQ_TICK, SEL_CTRL, 8'h00, 4'b0010));
        send_word(make_word(REQ_TICK, SEL_CTRL, 8'h00, 4'b1010));
        send_word(make_word(REQ_RD, SEL_HI0, 8'h00, 4'h0));

        for (int ph = 0; ph < 10; ph++) begin
            if (ph < 4) begin
                snd_idle_pct = 17;
                rcv_idle_pct = 84;
            end else if (ph < 7) begin
                snd_idle_pct = 84;
                rcv_idle_pct = 17;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            write_mode(phase_modes[ph]);
            if (ph == 1 || ph == 8) stall_requests++;
            start = words_sent;
            while (words_sent - start < 40) begin
                if ($urandom_range(9) < 7)
                    run_sequence();
                else
                    send_word(make_word(2'($urandom), 3'($urandom), 8'($urandom),
                                        4'($urandom)));
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d replies never arrived", tracker.pending()));
        $display("run covered %0d words under %0d mode byte settings", words_sent, modes_used);
        $display("%0d replies checked, %0d overflows predicted", tracker.checked,
                 tracker.overflows);
        if (tracker.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("FAILED: results differ");
        $finish;
    end
endmodule
